FILE: hw/rtl/chte_pkg.sv
// Shared constants and codes for the chained hash table engine.
package chte_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned FL_W    = 8;
  localparam int unsigned MC_W    = 7;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned MAX_OUT = 64;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd5;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL_YR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_ALL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CHANGE  = 3'd4;

  localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
  localparam logic [ST_W-1:0] STAT_NONE  = 2'd1;
  localparam logic [ST_W-1:0] STAT_FULL  = 2'd2;

endpackage

FILE: hw/rtl/chte_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module chte_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/chte_mod.sv
// Bit-serial remainder unit that reduces a year by the bucket count.
module chte_mod #(
  parameter int unsigned Ew = 5,
  parameter int unsigned Bw = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [chte_pkg::YEAR_W-1:0] dividend_i,
  input  logic [Ew-1:0]             divisor_i,
  output logic                      done_o,
  output logic [Bw-1:0]             rem_o
);

  logic [chte_pkg::YEAR_W-1:0] div_q, div_d;
  logic [Ew-1:0]               d_q, d_d;
  logic [Ew-1:0]               r_q, r_d;
  logic [4:0]                  cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [Ew:0]                 trial;

  always_comb begin
    div_d  = div_q;
    d_d    = d_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {r_q, div_q[chte_pkg::YEAR_W-1]};
    if (start_i) begin
      div_d  = dividend_i;
      d_d    = divisor_i;
      r_d    = '0;
      cnt_d  = 5'(chte_pkg::YEAR_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, d_q}) begin
        trial = trial - {1'b0, d_q};
      end
      r_d   = trial[Ew-1:0];
      div_d = {div_q[chte_pkg::YEAR_W-2:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    d_q   <= d_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q[Bw-1:0];

endmodule

FILE: hw/rtl/chained_hash_table_engine_unit.sv
// Top level of the chained hash table engine: command sequencer and bucket chains.
//
//   channel | direction | handshake             | payload
//   cmd     | in        | in_valid_i/in_stall_o | cmd, record_id, year, floors, new_year
//   result  | out       | out_valid_o/out_stall_i | status, id, year, floors, count, last
//   config  | in        | cfg_we_i              | bucket_count
//
// A command's time grows with each year reduction and with the number of chain links visited;
// the record memory's registered read sets the walk pace: S_RD reads a link, S_CHK checks it.
// A query walks its chain a second time only when it found matches, visiting S_QHIT for each reported record.
// Reset empties every bucket and frees every slot at once; no clearing pass is needed.
// A stalled result holds the sequencer only when the next result is ready to be loaded.
module chained_hash_table_engine_unit #(
  parameter int unsigned MAX_BUCKETS = 16,
  parameter int unsigned CAPACITY    = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [chte_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [chte_pkg::CMD_W-1:0]    cmd_i,
  input  logic [chte_pkg::ID_W-1:0]     record_id_i,
  input  logic [chte_pkg::YEAR_W-1:0]   year_i,
  input  logic [chte_pkg::FL_W-1:0]     floors_i,
  input  logic [chte_pkg::YEAR_W-1:0]   new_year_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [chte_pkg::ST_W-1:0]     status_o,
  output logic [chte_pkg::ID_W-1:0]     out_id_o,
  output logic [chte_pkg::YEAR_W-1:0]   out_year_o,
  output logic [chte_pkg::FL_W-1:0]     out_floors_o,
  output logic [chte_pkg::MC_W-1:0]     match_count_o,
  output logic                          last_o
);

  localparam int unsigned EW = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = (PW > 8) ? PW : 8;
  localparam int unsigned RECW = chte_pkg::ID_W + chte_pkg::YEAR_W + chte_pkg::FL_W;
  localparam int unsigned RW = PW + RECW;
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MOD1 = 4'd1;
  localparam logic [3:0] S_MOD2 = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_APP1 = 4'd5;
  localparam logic [3:0] S_APP2 = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;
  localparam logic [3:0] S_QHIT = 4'd8;

  logic [3:0]                  state_q, state_d;
  logic [chte_pkg::CFG_W-1:0]  cfg_q;
  logic [PW-1:0]               head_q [MAX_BUCKETS];
  logic [PW-1:0]               tail_q [MAX_BUCKETS];
  logic [PW-1:0]               head_d [MAX_BUCKETS];
  logic [PW-1:0]               tail_d [MAX_BUCKETS];
  logic [CAPACITY-1:0]         used_q, used_d;

  logic [chte_pkg::CMD_W-1:0]  cmd_q, cmd_d;
  logic [chte_pkg::ID_W-1:0]   id_q, id_d;
  logic [chte_pkg::YEAR_W-1:0] year_q, year_d;
  logic [chte_pkg::YEAR_W-1:0] ny_q, ny_d;
  logic [chte_pkg::ID_W-1:0]   ins_id_q, ins_id_d;
  logic [chte_pkg::YEAR_W-1:0] ins_year_q, ins_year_d;
  logic [chte_pkg::FL_W-1:0]   ins_fl_q, ins_fl_d;
  logic [BW-1:0]               cur_b_q, cur_b_d;
  logic [BW-1:0]               app_b_q, app_b_d;
  logic [PW-1:0]               p_q, p_d, prev_q, prev_d, s_q, s_d;
  logic [RECW-1:0]             prev_rec_q, prev_rec_d;
  logic [PW-1:0]               steps_q, steps_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [CW-1:0]               k_q, k_d;
  logic                        pass_q, pass_d;
  logic [chte_pkg::ST_W-1:0]   res_st_q, res_st_d;

  logic                        out_valid_q, out_valid_d;
  logic [chte_pkg::ST_W-1:0]   o_st_q, o_st_d;
  logic [chte_pkg::ID_W-1:0]   o_id_q, o_id_d;
  logic [chte_pkg::YEAR_W-1:0] o_yr_q, o_yr_d;
  logic [chte_pkg::FL_W-1:0]   o_fl_q, o_fl_d;
  logic [chte_pkg::MC_W-1:0]   o_mc_q, o_mc_d;
  logic                        o_last_q, o_last_d;
  logic                        out_load;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [RW-1:0]               ram_wdata, ram_rdata;
  logic [PW-1:0]               rd_next;
  logic [chte_pkg::ID_W-1:0]   rd_id;
  logic [chte_pkg::YEAR_W-1:0] rd_year;
  logic [chte_pkg::FL_W-1:0]   rd_fl;

  logic                        mod_start, mod_done;
  logic [chte_pkg::YEAR_W-1:0] mod_arg;
  logic [BW-1:0]               mod_rem;
  logic [8:0]                  cfg_ext, eff_ext;
  logic [EW-1:0]               eff;
  logic [PW-1:0]               free_slot;
  logic                        full;
  logic [CW-1:0]               total, mc_sat;
  logic                        hit, p_ok;

  assign cfg_ext = {4'd0, cfg_q};
  always_comb begin
    if (cfg_ext == 9'd0) begin
      eff_ext = 9'd1;
    end else if (cfg_ext > 9'(MAX_BUCKETS)) begin
      eff_ext = 9'(MAX_BUCKETS);
    end else begin
      eff_ext = cfg_ext;
    end
  end
  assign eff = eff_ext[EW-1:0];

  always_comb begin
    free_slot = NIL;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_slot = PW'(i);
      end
    end
  end
  assign full = &used_q;

  assign {rd_next, rd_id, rd_year, rd_fl} = ram_rdata;
  assign total  = (cnt_q > CW'(chte_pkg::MAX_OUT)) ? CW'(chte_pkg::MAX_OUT) : cnt_q;
  assign mc_sat = (cnt_q > CW'(127)) ? CW'(127) : cnt_q;
  assign p_ok   = (p_q < NIL) && (steps_q < NIL);

  chte_mod #(
    .Ew(EW),
    .Bw(BW)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(mod_arg),
    .divisor_i (eff),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  chte_ram #(
    .Width(RW),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    used_d     = used_q;
    cmd_d      = cmd_q;
    id_d       = id_q;
    year_d     = year_q;
    ny_d       = ny_q;
    ins_id_d   = ins_id_q;
    ins_year_d = ins_year_q;
    ins_fl_d   = ins_fl_q;
    cur_b_d    = cur_b_q;
    app_b_d    = app_b_q;
    p_d        = p_q;
    prev_d     = prev_q;
    s_d        = s_q;
    prev_rec_d = prev_rec_q;
    steps_d    = steps_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    pass_d     = pass_q;
    res_st_d   = res_st_q;
    mod_start  = 1'b0;
    mod_arg    = year_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = p_q[AW-1:0];
    out_load   = 1'b0;
    o_st_d     = o_st_q;
    o_id_d     = o_id_q;
    o_yr_d     = o_yr_q;
    o_fl_d     = o_fl_q;
    o_mc_d     = o_mc_q;
    o_last_d   = o_last_q;
    hit        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d      = cmd_i;
          id_d       = record_id_i;
          year_d     = year_i;
          ny_d       = new_year_i;
          ins_id_d   = record_id_i;
          ins_year_d = year_i;
          ins_fl_d   = floors_i;
          prev_d     = NIL;
          steps_d    = '0;
          cnt_d      = '0;
          k_d        = '0;
          pass_d     = 1'b0;
          if (cmd_i == chte_pkg::CMD_DEL_ALL) begin
            cur_b_d = '0;
            p_d     = head_q[0];
            state_d = S_RD;
          end else if (cmd_i inside {chte_pkg::CMD_INSERT, chte_pkg::CMD_DEL_YR,
                                     chte_pkg::CMD_QUERY, chte_pkg::CMD_CHANGE}) begin
            mod_start = 1'b1;
            mod_arg   = year_i;
            state_d   = S_MOD1;
          end
        end
      end
      S_MOD1: begin
        if (mod_done) begin
          cur_b_d = mod_rem;
          p_d     = head_q[mod_rem];
          if (cmd_q == chte_pkg::CMD_CHANGE) begin
            mod_start = 1'b1;
            mod_arg   = ny_q;
            state_d   = S_MOD2;
          end else if (cmd_q == chte_pkg::CMD_INSERT) begin
            if (full) begin
              res_st_d = chte_pkg::STAT_FULL;
              state_d  = S_DONE;
            end else begin
              s_d     = free_slot;
              app_b_d = mod_rem;
              used_d[free_slot[AW-1:0]] = 1'b1;
              state_d = S_APP1;
            end
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_MOD2: begin
        if (mod_done) begin
          app_b_d = mod_rem;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (p_ok) begin
          ram_re  = 1'b1;
          state_d = S_CHK;
        end else if (cmd_q == chte_pkg::CMD_DEL_ALL &&
                     ({1'b0, cur_b_q} + (BW+1)'(1)) < (BW+1)'(eff)) begin
          cur_b_d = cur_b_q + BW'(1);
          p_d     = head_q[cur_b_q + BW'(1)];
          prev_d  = NIL;
          steps_d = '0;
        end else if (cmd_q == chte_pkg::CMD_QUERY && !pass_q && cnt_q != '0) begin
          pass_d  = 1'b1;
          p_d     = head_q[cur_b_q];
          steps_d = '0;
        end else if (cmd_q == chte_pkg::CMD_QUERY && pass_q) begin
          state_d = S_IDLE;
        end else begin
          res_st_d = chte_pkg::STAT_NONE;
          state_d  = S_DONE;
        end
      end
      S_CHK: begin
        if (cmd_q == chte_pkg::CMD_QUERY) begin
          hit = (rd_year == year_q);
          if (pass_q && hit) begin
            state_d = S_QHIT;
          end else if (hit) begin
            cnt_d = cnt_q + CW'(1);
          end
        end else begin
          hit = (rd_id == id_q);
          if (hit) begin
            if (prev_q < NIL) begin
              ram_we    = 1'b1;
              ram_waddr = prev_q[AW-1:0];
              ram_wdata = {rd_next, prev_rec_q};
            end else begin
              head_d[cur_b_q] = rd_next;
            end
            if (tail_q[cur_b_q] == p_q) begin
              tail_d[cur_b_q] = prev_q;
            end
            if (cmd_q == chte_pkg::CMD_CHANGE) begin
              s_d        = p_q;
              ins_id_d   = rd_id;
              ins_fl_d   = rd_fl;
              ins_year_d = ny_q;
              state_d    = S_APP1;
            end else begin
              used_d[p_q[AW-1:0]] = 1'b0;
              res_st_d = chte_pkg::STAT_OK;
              state_d  = S_DONE;
            end
          end
        end
        if (!hit || (cmd_q == chte_pkg::CMD_QUERY && !pass_q)) begin
          prev_rec_d = {rd_id, rd_year, rd_fl};
          prev_d     = p_q;
          p_d        = rd_next;
          steps_d    = steps_q + PW'(1);
          state_d    = S_RD;
        end
      end
      S_APP1: begin
        ram_we    = 1'b1;
        ram_waddr = s_q[AW-1:0];
        ram_wdata = {NIL, ins_id_q, ins_year_q, ins_fl_q};
        res_st_d  = chte_pkg::STAT_OK;
        if (head_q[app_b_q] >= NIL || tail_q[app_b_q] >= NIL) begin
          head_d[app_b_q] = s_q;
          tail_d[app_b_q] = s_q;
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = tail_q[app_b_q][AW-1:0];
          state_d   = S_APP2;
        end
      end
      S_APP2: begin
        ram_we    = 1'b1;
        ram_waddr = tail_q[app_b_q][AW-1:0];
        ram_wdata = {s_q, rd_id, rd_year, rd_fl};
        tail_d[app_b_q] = s_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q) begin
          out_load = 1'b1;
          o_st_d   = res_st_q;
          o_id_d   = '0;
          o_yr_d   = '0;
          o_fl_d   = '0;
          o_mc_d   = '0;
          o_last_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_QHIT: begin
        if (!out_valid_q) begin
          out_load = 1'b1;
          o_st_d   = chte_pkg::STAT_OK;
          o_id_d   = rd_id;
          o_yr_d   = rd_year;
          o_fl_d   = rd_fl;
          o_mc_d   = mc_sat[chte_pkg::MC_W-1:0];
          o_last_d = ((k_q + CW'(1)) == total);
          k_d      = k_q + CW'(1);
          if ((k_q + CW'(1)) == total) begin
            state_d = S_IDLE;
          end else begin
            prev_d  = p_q;
            p_d     = rd_next;
            steps_d = steps_q + PW'(1);
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= chte_pkg::CFG_RESET;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_BUCKETS; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
      end
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    id_q       <= id_d;
    year_q     <= year_d;
    ny_q       <= ny_d;
    ins_id_q   <= ins_id_d;
    ins_year_q <= ins_year_d;
    ins_fl_q   <= ins_fl_d;
    cur_b_q    <= cur_b_d;
    app_b_q    <= app_b_d;
    p_q        <= p_d;
    prev_q     <= prev_d;
    s_q        <= s_d;
    prev_rec_q <= prev_rec_d;
    steps_q    <= steps_d;
    cnt_q      <= cnt_d;
    k_q        <= k_d;
    pass_q     <= pass_d;
    res_st_q   <= res_st_d;
    o_st_q     <= o_st_d;
    o_id_q     <= o_id_d;
    o_yr_q     <= o_yr_d;
    o_fl_q     <= o_fl_d;
    o_mc_q     <= o_mc_d;
    o_last_q   <= o_last_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = o_st_q;
  assign out_id_o      = o_id_q;
  assign out_year_o    = o_yr_q;
  assign out_floors_o  = o_fl_q;
  assign match_count_o = o_mc_q;
  assign last_o        = o_last_q;

  a_chk_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> $past(ram_re))
    else $error("Chain check without a preceding memory read.");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> (steps_q < NIL) && (p_q < NIL))
    else $error("Chain walk exceeded its bound.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q)
    else $error("Result register overwritten while a result waits.");

  a_app2_after_app1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APP2) |-> $past(state_q) == S_APP1)
    else $error("Tail relink without the append step.");

endmodule
